// ===== hdl/smpq_pkg.sv =====
// ============================================================================
// smpq_pkg
// Shared types and constants for the sorted maximum priority queue.
// ============================================================================
`default_nettype none

package smpq_pkg;

    // Number of entries the queue holds.
    localparam int CAPACITY   = 64;
    // Label bits kept per entry.
    localparam int LABEL_BITS = 16;
    // Label width as stored; the label port carries 16 bits.
    localparam int LAB_W      = (LABEL_BITS < 16) ? LABEL_BITS : 16;
    // Count register wide enough to hold CAPACITY itself.
    localparam int CNT_W      = $clog2(CAPACITY + 1);

    localparam int LABEL_PORT_W = 16;
    localparam int PRI_W        = 32;
    localparam int COUNT_OUT_W  = 7;

    typedef enum logic [1:0] {
        ACT_INSERT = 2'd0,
        ACT_REMOVE = 2'd1,
        ACT_CHANGE = 2'd2
    } action_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_EMPTY     = 2'd1,
        ST_FULL      = 2'd2,
        ST_NOT_FOUND = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_APPLY,
        S_DONE
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;  // latch request word and compare vectors
        logic apply;    // update cells, count and result registers
    } smpq_cmd_t;

endpackage

`default_nettype wire

// ===== hdl/smpq_ctrl.sv =====
// ============================================================================
// smpq_ctrl
// Controller: capture, apply, then present the result for one cycle.
// ============================================================================
`default_nettype none

module smpq_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    output smpq_pkg::smpq_cmd_t      cmd,
    output logic                     busy,
    output logic                     done
);

    smpq_pkg::state_t state_reg;
    smpq_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= smpq_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        cmd.capture = 1'b0;
        cmd.apply   = 1'b0;
        busy        = 1'b0;
        done        = 1'b0;
        unique case (state_reg)
            smpq_pkg::S_IDLE:
            begin
                if (start)
                begin
                    cmd.capture = 1'b1;
                    state_next  = smpq_pkg::S_APPLY;
                end
            end
            smpq_pkg::S_APPLY:
            begin
                busy       = 1'b1;
                cmd.apply  = 1'b1;
                state_next = smpq_pkg::S_DONE;
            end
            smpq_pkg::S_DONE:
            begin
                // result on the ports now; a new word may enter at once
                done = 1'b1;
                if (start)
                begin
                    cmd.capture = 1'b1;
                    state_next  = smpq_pkg::S_APPLY;
                end
                else
                begin
                    state_next = smpq_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = smpq_pkg::S_IDLE;
            end
        endcase
    end

`ifndef NO_ASSERTIONS
    a_apply_then_done: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.apply |=> done)
        else $error("apply not followed by result strobe");

    a_done_after_apply: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(cmd.apply))
        else $error("result strobe without apply");
`endif

endmodule

`default_nettype wire

// ===== hdl/smpq_datapath.sv =====
// ============================================================================
// smpq_datapath
// Row of cells (sorted but for lowered entries) with compare-all and parallel shift, plus result regs.
// ============================================================================
`default_nettype none

module smpq_datapath (
    input  wire logic                                       clk,
    input  wire logic                                       rst_n,
    input  wire smpq_pkg::smpq_cmd_t                        cmd,
    input  wire logic [1:0]                                 action,
    input  wire logic [smpq_pkg::LABEL_PORT_W-1:0]          label,
    input  wire logic signed [smpq_pkg::PRI_W-1:0]          priority_req,
    output logic [smpq_pkg::LABEL_PORT_W-1:0]               removed_label,
    output logic signed [smpq_pkg::PRI_W-1:0]               removed_priority,
    output logic [smpq_pkg::LABEL_PORT_W-1:0]               head_label,
    output logic signed [smpq_pkg::PRI_W-1:0]               head_priority,
    output logic [smpq_pkg::COUNT_OUT_W-1:0]                entry_count,
    output logic                                            is_empty,
    output logic [1:0]                                      status
);

    localparam int CAP = smpq_pkg::CAPACITY;

    // cell storage
    logic [smpq_pkg::LAB_W-1:0]        lab_reg [CAP];
    logic signed [smpq_pkg::PRI_W-1:0] pri_reg [CAP];
    logic [smpq_pkg::CNT_W-1:0]        count_reg;
    logic [smpq_pkg::CNT_W-1:0]        count_next;

    // captured request
    logic [1:0]                        act_reg;
    logic [smpq_pkg::LAB_W-1:0]        req_lab_reg;
    logic signed [smpq_pkg::PRI_W-1:0] req_pri_reg;
    logic [CAP-1:0]                    ge_reg;
    logic [CAP-1:0]                    lt_reg;
    logic [CAP-1:0]                    match_reg;
    logic [CAP-1:0]                    ge_cmp;
    logic [CAP-1:0]                    lt_cmp;
    logic [CAP-1:0]                    match_cmp;

    // result registers
    logic [1:0]                        status_reg;
    logic [1:0]                        status_next;
    logic [smpq_pkg::LAB_W-1:0]        rem_lab_reg;
    logic signed [smpq_pkg::PRI_W-1:0] rem_pri_reg;

    // apply-cycle decode
    logic [CAP-1:0] pre;        // match at this cell or earlier
    logic [CAP-1:0] pre_sh;     // match strictly earlier
    logic [CAP-1:0] first_hit;
    logic [CAP-1:0] blk;        // a not-lower cell ahead of the hit at or after here
    logic [CAP-1:0] region;
    logic [CAP-1:0] ins_pre;    // insert slot at this cell or earlier
    logic [CAP-1:0] ins_sh;     // insert slot strictly earlier
    logic           found;
    logic           move_up;
    logic           full;
    logic           empty;

    assign full  = (count_reg == smpq_pkg::CNT_W'(CAP));
    assign empty = (count_reg == '0);

    // Compare-all against the incoming word; only cells below count count.
    always_comb
    begin
        for (int k = 0; k < CAP; k++)
        begin
            ge_cmp[k]    = (smpq_pkg::CNT_W'(k) < count_reg) && (pri_reg[k] >= priority_req);
            lt_cmp[k]    = (smpq_pkg::CNT_W'(k) < count_reg) && !(pri_reg[k] >= priority_req);
            match_cmp[k] = (smpq_pkg::CNT_W'(k) < count_reg)
                           && (lab_reg[k] == label[smpq_pkg::LAB_W-1:0]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            act_reg     <= action;
            req_lab_reg <= label[smpq_pkg::LAB_W-1:0];
            req_pri_reg <= priority_req;
            ge_reg      <= ge_cmp;
            lt_reg      <= lt_cmp;
            match_reg   <= match_cmp;
        end
    end

    // Prefix/suffix ORs, log-depth. Lowered entries stay in place, so the
    // row is not always sorted: ge and lt runs are found explicitly.
    always_comb
    begin
        pre = match_reg;
        for (int s = 1; s < CAP; s = s * 2)
        begin
            pre = pre | (pre << s);
        end
        pre_sh    = pre << 1;
        first_hit = match_reg & ~pre_sh;
        found     = |match_reg;
        // new priority strictly above the old one at the first hit
        move_up   = |(first_hit & lt_reg);
        // unbroken run of lower-priority cells ending at the hit
        blk = ~lt_reg & ~pre;
        for (int s = 1; s < CAP; s = s * 2)
        begin
            blk = blk | (blk >> s);
        end
        region    = ~pre_sh & ~blk;
        // insert lands at the first cell that is not ge; the rest shift back
        ins_pre = ~ge_reg;
        for (int s = 1; s < CAP; s = s * 2)
        begin
            ins_pre = ins_pre | (ins_pre << s);
        end
        ins_sh    = ins_pre << 1;
    end

    // Per-cell next value: each cell sees only itself and its two neighbors.
    for (genvar k = 0; k < CAP; k++)
    begin : g_cell
        logic [smpq_pkg::LAB_W-1:0]        lab_prv;
        logic [smpq_pkg::LAB_W-1:0]        lab_fol;
        logic [smpq_pkg::LAB_W-1:0]        lab_nx;
        logic signed [smpq_pkg::PRI_W-1:0] pri_prv;
        logic signed [smpq_pkg::PRI_W-1:0] pri_fol;
        logic signed [smpq_pkg::PRI_W-1:0] pri_nx;
        logic                              lt_prv;

        if (k == 0)
        begin : g_head
            assign lab_prv = '0;
            assign pri_prv = '0;
            assign lt_prv  = 1'b0;
        end
        else
        begin : g_body
            assign lab_prv = lab_reg[k-1];
            assign pri_prv = pri_reg[k-1];
            assign lt_prv  = lt_reg[k-1];
        end

        if (k == CAP - 1)
        begin : g_tail
            assign lab_fol = lab_reg[k];
            assign pri_fol = pri_reg[k];
        end
        else
        begin : g_mid
            assign lab_fol = lab_reg[k+1];
            assign pri_fol = pri_reg[k+1];
        end

        always_comb
        begin
            lab_nx = lab_reg[k];
            pri_nx = pri_reg[k];
            if (cmd.apply)
            begin
                case (act_reg)
                    smpq_pkg::ACT_INSERT:
                    begin
                        // cells from the insert slot on shift back; the slot takes the word
                        if (!full && ins_pre[k])
                        begin
                            if (!ins_sh[k])
                            begin
                                lab_nx = req_lab_reg;
                                pri_nx = req_pri_reg;
                            end
                            else
                            begin
                                lab_nx = lab_prv;
                                pri_nx = pri_prv;
                            end
                        end
                    end
                    smpq_pkg::ACT_REMOVE:
                    begin
                        if (!empty)
                        begin
                            lab_nx = lab_fol;
                            pri_nx = pri_fol;
                        end
                    end
                    smpq_pkg::ACT_CHANGE:
                    begin
                        if (move_up && region[k])
                        begin
                            if (lt_prv)
                            begin
                                lab_nx = lab_prv;
                                pri_nx = pri_prv;
                            end
                            else
                            begin
                                lab_nx = req_lab_reg;
                                pri_nx = req_pri_reg;
                            end
                        end
                        else if (!move_up && first_hit[k])
                        begin
                            pri_nx = req_pri_reg;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
        end

        always_ff @(posedge clk)
        begin
            lab_reg[k] <= lab_nx;
            pri_reg[k] <= pri_nx;
        end
    end

    // Count and status.
    always_comb
    begin
        count_next  = count_reg;
        status_next = smpq_pkg::ST_OK;
        case (act_reg)
            smpq_pkg::ACT_INSERT:
            begin
                if (full)
                begin
                    status_next = smpq_pkg::ST_FULL;
                end
                else
                begin
                    count_next = count_reg + smpq_pkg::CNT_W'(1);
                end
            end
            smpq_pkg::ACT_REMOVE:
            begin
                if (empty)
                begin
                    status_next = smpq_pkg::ST_EMPTY;
                end
                else
                begin
                    count_next = count_reg - smpq_pkg::CNT_W'(1);
                end
            end
            smpq_pkg::ACT_CHANGE:
            begin
                if (!found)
                begin
                    status_next = smpq_pkg::ST_NOT_FOUND;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (cmd.apply)
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.apply)
        begin
            status_reg <= status_next;
            if (act_reg == smpq_pkg::ACT_REMOVE && !empty)
            begin
                rem_lab_reg <= lab_reg[0];
                rem_pri_reg <= pri_reg[0];
            end
            else
            begin
                rem_lab_reg <= '0;
                rem_pri_reg <= '0;
            end
        end
    end

    assign removed_label    = smpq_pkg::LABEL_PORT_W'(rem_lab_reg);
    assign removed_priority = rem_pri_reg;
    assign head_label       = (count_reg != '0) ? smpq_pkg::LABEL_PORT_W'(lab_reg[0]) : '0;
    assign head_priority    = (count_reg != '0) ? pri_reg[0] : '0;
    assign entry_count      = smpq_pkg::COUNT_OUT_W'(count_reg);
    assign is_empty         = (count_reg == '0);
    assign status           = status_reg;

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= smpq_pkg::CNT_W'(CAP))
        else $error("entry count above capacity");

    a_empty_remove: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.apply && act_reg == smpq_pkg::ACT_REMOVE && empty)
        |=> (status_reg == smpq_pkg::ST_EMPTY && count_reg == '0))
        else $error("remove on empty changed state or status");
`endif

endmodule

`default_nettype wire

// ===== hdl/sorted_max_priority_queue.sv =====
// ============================================================================
// sorted_max_priority_queue
// Sorted list priority queue: insert, remove head, change priority of label.
// ============================================================================
// Sequence: a word accepted in idle or done passes the apply state and gives
//   its result strobe (done) in done; the strobe lasts exactly one cycle.
// A new word is taken only in idle or done, set by the capture/apply sequence
//   of the cell row (compare-all at accept, parallel shift at apply).
// busy is high only in the apply cycle; start may be given while done shows.
// Reset (rst_n, async, active low) empties the queue; cell contents undefined.
// ============================================================================
`default_nettype none

module sorted_max_priority_queue (
    input  wire logic                                       clk,
    input  wire logic                                       rst_n,
    // command side: word taken when start is high and busy is low
    input  wire logic                                       start,
    output logic                                            busy,
    input  wire logic [1:0]                                 action,
    input  wire logic [smpq_pkg::LABEL_PORT_W-1:0]          label,
    input  wire logic signed [smpq_pkg::PRI_W-1:0]          priority_req,
    // result side: valid for the single cycle done is high
    output logic                                            done,
    output logic [smpq_pkg::LABEL_PORT_W-1:0]               removed_label,
    output logic signed [smpq_pkg::PRI_W-1:0]               removed_priority,
    output logic [smpq_pkg::LABEL_PORT_W-1:0]               head_label,
    output logic signed [smpq_pkg::PRI_W-1:0]               head_priority,
    output logic [smpq_pkg::COUNT_OUT_W-1:0]                entry_count,
    output logic                                            is_empty,
    output logic [1:0]                                      status
);

    smpq_pkg::smpq_cmd_t cmd;

    // sequencing: idle -> apply -> done (-> apply on back-to-back start)
    smpq_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .cmd   (cmd),
        .busy  (busy),
        .done  (done)
    );

    // cell row, compare vectors, count and result registers
    smpq_datapath u_datapath (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .action           (action),
        .label            (label),
        .priority_req     (priority_req),
        .removed_label    (removed_label),
        .removed_priority (removed_priority),
        .head_label       (head_label),
        .head_priority    (head_priority),
        .entry_count      (entry_count),
        .is_empty         (is_empty),
        .status           (status)
    );

endmodule

`default_nettype wire
